FILE: hw/rtl/bfpa_pkg.sv
// Shared types and constants of the best-fit partition allocator.
package bfpa_pkg;

  localparam int AddrW  = 20;
  localparam int IdW    = 16;
  localparam int TimeW  = 16;
  localparam int TlW    = 17;
  localparam int OpW    = 3;
  localparam int StatW  = 3;
  localparam int FreedW = 6;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC   = 3'd0,
    OP_FREE    = 3'd1,
    OP_TICK    = 3'd2,
    OP_COMPACT = 3'd3,
    OP_QUERY   = 3'd4
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 3'd0,
    ST_NO_FIT  = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_DUP     = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_INSERT,
    S_RESP
  } state_e;

  // One job record, kept in address order in the table memory
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] size;
    logic [TlW-1:0]   tl;
  } entry_t;

  // Command from the sequencer to the gap tracker
  typedef struct packed {
    logic             clr;
    logic             upd;
    logic [AddrW-1:0] lim;
    logic [AddrW-1:0] nxt_end;
  } gap_cmd_t;

endpackage

FILE: hw/rtl/bfpa_if.sv
// Request and response channel interfaces of the allocator.
interface bfpa_req_if;
  logic                        valid;
  logic                        ready;
  logic [bfpa_pkg::OpW-1:0]    op;
  logic [bfpa_pkg::IdW-1:0]    job_id;
  logic [bfpa_pkg::AddrW-1:0]  job_size;
  logic [bfpa_pkg::TimeW-1:0]  job_time;
  logic [bfpa_pkg::TimeW-1:0]  elapsed;
  modport source (output valid, op, job_id, job_size, job_time, elapsed, input ready);
  modport sink   (input valid, op, job_id, job_size, job_time, elapsed, output ready);
endinterface

interface bfpa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bfpa_pkg::StatW-1:0]  status;
  logic [bfpa_pkg::AddrW-1:0]  start_addr;
  logic [bfpa_pkg::AddrW-1:0]  free_units;
  logic [bfpa_pkg::FreedW-1:0] freed_count;
  modport source (output valid, status, start_addr, free_units, freed_count, input ready);
  modport sink   (input valid, status, start_addr, free_units, freed_count, output ready);
endinterface

FILE: hw/rtl/bfpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module bfpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: hw/rtl/bfpa_gap.sv
// Best-fit gap tracker: walks gaps in address order and keeps the smallest fit.
module bfpa_gap #(
  parameter int CountW = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bfpa_pkg::gap_cmd_t         cmd_i,
  input  logic [CountW-1:0]          pos_i,
  input  logic [bfpa_pkg::AddrW-1:0] req_size_i,
  output logic                       found_o,
  output logic [bfpa_pkg::AddrW-1:0] best_addr_o,
  output logic [CountW-1:0]          best_pos_o
);
  logic [bfpa_pkg::AddrW-1:0] prev_end_q, prev_end_d;
  logic [bfpa_pkg::AddrW-1:0] best_gap_q, best_gap_d;
  logic [bfpa_pkg::AddrW-1:0] best_addr_q, best_addr_d;
  logic [CountW-1:0]          best_pos_q, best_pos_d;
  logic                       found_q, found_d;
  logic [bfpa_pkg::AddrW-1:0] gap;
  logic                       fits;

  // Gap ahead of the current limit and the best-fit test
  always_comb begin
    gap  = cmd_i.lim - prev_end_q;
    fits = (req_size_i != '0) && (cmd_i.lim >= prev_end_q) && (gap >= req_size_i) &&
           (!found_q || (gap < best_gap_q));
    prev_end_d  = prev_end_q;
    best_gap_d  = best_gap_q;
    best_addr_d = best_addr_q;
    best_pos_d  = best_pos_q;
    found_d     = found_q;
    if (cmd_i.clr) begin
      prev_end_d = '0;
      found_d    = 1'b0;
    end else if (cmd_i.upd) begin
      if (fits) begin
        found_d     = 1'b1;
        best_gap_d  = gap;
        best_addr_d = prev_end_q;
        best_pos_d  = pos_i;
      end
      if (cmd_i.nxt_end > prev_end_q) begin
        prev_end_d = cmd_i.nxt_end;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q    <= 1'b0;
      prev_end_q <= '0;
    end else begin
      found_q    <= found_d;
      prev_end_q <= prev_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_gap_q  <= best_gap_d;
    best_addr_q <= best_addr_d;
    best_pos_q  <= best_pos_d;
  end

  assign found_o     = found_q;
  assign best_addr_o = best_addr_q;
  assign best_pos_o  = best_pos_q;
endmodule

FILE: hw/rtl/best_fit_partition_allocator.sv
// Top level: sequencer over the address-ordered job table memory.
//
//  channel  | dir | transfer when       | payload
//  ---------+-----+---------------------+-----------------------------------------
//  req_i    | in  | valid && ready      | op, job_id, job_size, job_time, elapsed
//  rsp_o    | out | valid && ready      | status, start_addr, free_units, freed_count
//  cfg      | in  | cfg_we_i            | cfg_wdata_i = mem_size
//
// Jobs sit in the table RAM sorted by start address, one read per cycle.
// Free, tick, compact and query take one pass over the table.
// Allocate takes a pass plus a shift of the entries above the chosen gap.
// Reset and a mem_size write empty the table at once.
// A new request is taken in idle even while the last response still waits.
module best_fit_partition_allocator #(
  parameter int MAX_JOBS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bfpa_req_if.sink                   req_i,
  bfpa_rsp_if.source                 rsp_o,
  input  logic                       cfg_we_i,
  input  logic [bfpa_pkg::AddrW-1:0] cfg_wdata_i
);
  localparam int PosW   = $clog2(MAX_JOBS);
  localparam int CountW = $clog2(MAX_JOBS + 1);
  localparam int EntW   = $bits(bfpa_pkg::entry_t);
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_JOBS);
  localparam logic [CountW-1:0] One      = CountW'(1);

  bfpa_pkg::state_e state_q, state_d;

  logic [bfpa_pkg::OpW-1:0]    op_q, op_d;
  logic [bfpa_pkg::IdW-1:0]    id_q, id_d;
  logic [bfpa_pkg::AddrW-1:0]  size_q, size_d;
  logic [bfpa_pkg::TimeW-1:0]  time_q, time_d;
  logic [bfpa_pkg::TimeW-1:0]  elapsed_q, elapsed_d;

  logic [bfpa_pkg::AddrW-1:0]  mem_size_q;
  logic [bfpa_pkg::AddrW-1:0]  free_q, free_d;
  logic [CountW-1:0]           count_q, count_d;
  logic [CountW-1:0]           rd_idx_q, rd_idx_d;
  logic [CountW-1:0]           wr_idx_q, wr_idx_d;
  logic [CountW-1:0]           pend_pos_q, pend_pos_d;
  logic                        pend_q, pend_d;
  logic                        issue_q, issue_d;
  logic                        hit_q, hit_d;
  logic                        dup_q, dup_d;
  logic [bfpa_pkg::AddrW-1:0]  at_q, at_d;
  logic [bfpa_pkg::FreedW-1:0] freed_q, freed_d;
  logic [bfpa_pkg::StatW-1:0]  res_status_q, res_status_d;
  logic [bfpa_pkg::AddrW-1:0]  res_addr_q, res_addr_d;

  logic                        out_v_q, out_v_d;
  logic [bfpa_pkg::StatW-1:0]  out_status_q, out_status_d;
  logic [bfpa_pkg::AddrW-1:0]  out_addr_q, out_addr_d;
  logic [bfpa_pkg::AddrW-1:0]  out_free_q, out_free_d;
  logic [bfpa_pkg::FreedW-1:0] out_freed_q, out_freed_d;

  // Table memory port signals
  logic                        ram_we;
  logic [PosW-1:0]             ram_waddr;
  logic [PosW-1:0]             ram_raddr;
  logic [EntW-1:0]             ram_wdata;
  logic [EntW-1:0]             ram_rdata;
  bfpa_pkg::entry_t            rd_ent;
  bfpa_pkg::entry_t            wr_ent;

  // Gap tracker
  bfpa_pkg::gap_cmd_t          gcmd;
  logic [CountW-1:0]           gpos;
  logic                        g_found;
  logic [bfpa_pkg::AddrW-1:0]  g_addr;
  logic [CountW-1:0]           g_pos;

  logic                        expired;
  logic                        id_match;

  assign rd_ent    = bfpa_pkg::entry_t'(ram_rdata);
  assign ram_wdata = EntW'(wr_ent);

  bfpa_ram #(
    .WIDTH (EntW),
    .DEPTH (MAX_JOBS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bfpa_gap #(
    .CountW (CountW)
  ) u_gap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (gcmd),
    .pos_i       (gpos),
    .req_size_i  (size_q),
    .found_o     (g_found),
    .best_addr_o (g_addr),
    .best_pos_o  (g_pos)
  );

  assign req_i.ready       = (state_q == bfpa_pkg::S_IDLE);
  assign rsp_o.valid       = out_v_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.start_addr  = out_addr_q;
  assign rsp_o.free_units  = out_free_q;
  assign rsp_o.freed_count = out_freed_q;

  assign expired  = ({1'b0, elapsed_q} >= rd_ent.tl);
  assign id_match = (rd_ent.id == id_q);

  // Next state, table access and result bookkeeping
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    id_d         = id_q;
    size_d       = size_q;
    time_d       = time_q;
    elapsed_d    = elapsed_q;
    free_d       = free_q;
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    wr_idx_d     = wr_idx_q;
    pend_pos_d   = pend_pos_q;
    pend_d       = 1'b0;
    issue_d      = issue_q;
    hit_d        = hit_q;
    dup_d        = dup_q;
    at_d         = at_q;
    freed_d      = freed_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_v_d      = out_v_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_free_d   = out_free_q;
    out_freed_d  = out_freed_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_raddr    = rd_idx_q[PosW-1:0];
    wr_ent       = rd_ent;
    gcmd         = '0;
    gpos         = pend_pos_q;

    unique case (state_q)
      bfpa_pkg::S_IDLE: begin
        if (req_i.valid) begin
          op_d         = req_i.op;
          id_d         = req_i.job_id;
          size_d       = req_i.job_size;
          time_d       = req_i.job_time;
          elapsed_d    = req_i.elapsed;
          rd_idx_d     = '0;
          wr_idx_d     = '0;
          hit_d        = 1'b0;
          dup_d        = 1'b0;
          at_d         = '0;
          freed_d      = '0;
          res_status_d = bfpa_pkg::ST_OK;
          res_addr_d   = '0;
          gcmd.clr     = 1'b1;
          state_d      = bfpa_pkg::S_SCAN;
        end
      end

      bfpa_pkg::S_SCAN: begin
        // Handle the entry read in the previous cycle
        if (pend_q) begin
          unique case (op_q)
            bfpa_pkg::OP_ALLOC: begin
              if (id_match) begin
                dup_d = 1'b1;
              end
              gcmd.upd     = 1'b1;
              gcmd.lim     = rd_ent.start;
              gcmd.nxt_end = rd_ent.start + rd_ent.size;
            end
            bfpa_pkg::OP_FREE: begin
              if (id_match && !hit_q) begin
                hit_d   = 1'b1;
                free_d  = free_q + rd_ent.size;
                freed_d = bfpa_pkg::FreedW'(1);
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wr_idx_q[PosW-1:0];
                wr_idx_d  = wr_idx_q + One;
              end
            end
            bfpa_pkg::OP_TICK: begin
              if (expired) begin
                free_d = free_q + rd_ent.size;
                if (freed_q != '1) begin
                  freed_d = freed_q + bfpa_pkg::FreedW'(1);
                end
              end else begin
                wr_ent.tl = rd_ent.tl - {1'b0, elapsed_q};
                ram_we    = 1'b1;
                ram_waddr = wr_idx_q[PosW-1:0];
                wr_idx_d  = wr_idx_q + One;
              end
            end
            bfpa_pkg::OP_COMPACT: begin
              wr_ent.start = at_q;
              ram_we       = 1'b1;
              ram_waddr    = pend_pos_q[PosW-1:0];
              at_d         = at_q + rd_ent.size;
            end
            bfpa_pkg::OP_QUERY: begin
              if (id_match && !hit_q) begin
                hit_d      = 1'b1;
                res_addr_d = rd_ent.start;
              end
            end
            default: begin
            end
          endcase
        end

        // Issue the next read, or close the pass
        if (rd_idx_q < count_q) begin
          pend_d     = 1'b1;
          pend_pos_d = rd_idx_q;
          rd_idx_d   = rd_idx_q + One;
        end else if (!pend_q) begin
          unique case (op_q)
            bfpa_pkg::OP_ALLOC: begin
              // Trailing gap up to the end of the space
              gcmd.upd = 1'b1;
              gcmd.lim = mem_size_q;
              gpos     = count_q;
              state_d  = bfpa_pkg::S_DECIDE;
            end
            bfpa_pkg::OP_FREE: begin
              res_status_d = hit_q ? bfpa_pkg::ST_OK : bfpa_pkg::ST_UNKNOWN;
              count_d      = wr_idx_q;
              state_d      = bfpa_pkg::S_RESP;
            end
            bfpa_pkg::OP_TICK: begin
              count_d = wr_idx_q;
              state_d = bfpa_pkg::S_RESP;
            end
            bfpa_pkg::OP_QUERY: begin
              res_status_d = hit_q ? bfpa_pkg::ST_OK : bfpa_pkg::ST_UNKNOWN;
              state_d      = bfpa_pkg::S_RESP;
            end
            default: begin
              state_d = bfpa_pkg::S_RESP;
            end
          endcase
        end
      end

      bfpa_pkg::S_DECIDE: begin
        priority if (dup_q) begin
          res_status_d = bfpa_pkg::ST_DUP;
          state_d      = bfpa_pkg::S_RESP;
        end else if (count_q == MaxCount) begin
          res_status_d = bfpa_pkg::ST_FULL;
          state_d      = bfpa_pkg::S_RESP;
        end else if (!g_found) begin
          res_status_d = bfpa_pkg::ST_NO_FIT;
          state_d      = bfpa_pkg::S_RESP;
        end else if (g_pos == count_q) begin
          state_d = bfpa_pkg::S_INSERT;
        end else begin
          rd_idx_d = count_q - One;
          issue_d  = 1'b1;
          state_d  = bfpa_pkg::S_SHIFT;
        end
      end

      bfpa_pkg::S_SHIFT: begin
        // Move entries above the chosen gap up by one, top first
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = PosW'(pend_pos_q + One);
        end
        if (issue_q) begin
          pend_d     = 1'b1;
          pend_pos_d = rd_idx_q;
          if (rd_idx_q == g_pos) begin
            issue_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q - One;
          end
        end else if (!pend_q) begin
          state_d = bfpa_pkg::S_INSERT;
        end
      end

      bfpa_pkg::S_INSERT: begin
        wr_ent.id    = id_q;
        wr_ent.start = g_addr;
        wr_ent.size  = size_q;
        wr_ent.tl    = {1'b0, time_q};
        ram_we       = 1'b1;
        ram_waddr    = g_pos[PosW-1:0];
        count_d      = count_q + One;
        free_d       = free_q - size_q;
        res_addr_d   = g_addr;
        state_d      = bfpa_pkg::S_RESP;
      end

      bfpa_pkg::S_RESP: begin
        if (!out_v_q || rsp_o.ready) begin
          out_v_d      = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          out_free_d   = free_q;
          out_freed_d  = freed_q;
          state_d      = bfpa_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bfpa_pkg::S_IDLE;
      end
    endcase

    // A size write empties the table
    if (cfg_we_i) begin
      count_d = '0;
      free_d  = cfg_wdata_i;
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfpa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= '0;
      free_q     <= '0;
      count_q    <= '0;
      pend_q     <= 1'b0;
      issue_q    <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mem_size_q <= cfg_wdata_i;
      end
      free_q  <= free_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      issue_q <= issue_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    id_q         <= id_d;
    size_q       <= size_d;
    time_q       <= time_d;
    elapsed_q    <= elapsed_d;
    rd_idx_q     <= rd_idx_d;
    wr_idx_q     <= wr_idx_d;
    pend_pos_q   <= pend_pos_d;
    hit_q        <= hit_d;
    dup_q        <= dup_d;
    at_q         <= at_d;
    freed_q      <= freed_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
    out_free_q   <= out_free_d;
    out_freed_q  <= out_freed_d;
  end
endmodule

FILE: dv/bfpa_checker.sv
// Checker: watches request and response transfers, predicts results, compares.
module bfpa_checker
  import bfpa_pkg::*;
#(
  parameter int MAX_JOBS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bfpa_req_if.sink         req,
  bfpa_rsp_if.sink         rsp,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_wdata_i,
  output int               fail_cnt,
  output int               pending_cnt,
  output int               rsp_cnt
);

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [AddrW-1:0]  start_addr;
    logic [AddrW-1:0]  free_units;
    logic [FreedW-1:0] freed_count;
  } alloc_rsp_t;

  // Shadow job table
  logic [AddrW-1:0] mem_units;
  logic [AddrW-1:0] free_sum;
  logic             job_vld [MAX_JOBS];
  logic [IdW-1:0]   job_id  [MAX_JOBS];
  logic [AddrW-1:0] job_base[MAX_JOBS];
  logic [AddrW-1:0] job_len [MAX_JOBS];
  logic [TlW-1:0]   job_life[MAX_JOBS];

  alloc_rsp_t expected_rsps[$];

  function automatic int lookup_job(logic [IdW-1:0] id);
    for (int i = 0; i < MAX_JOBS; i++)
      if (job_vld[i] && job_id[i] == id) return i;
    return -1;
  endfunction

  // Valid slots in ascending start order (stable insertion sort)
  function automatic int order_jobs(ref int ord[MAX_JOBS]);
    int n;
    int k;
    n = 0;
    for (int i = 0; i < MAX_JOBS; i++) begin
      if (!job_vld[i]) continue;
      k = n;
      n++;
      while (k > 0 && job_base[ord[k-1]] > job_base[i]) begin
        ord[k] = ord[k-1];
        k--;
      end
      ord[k] = i;
    end
    return n;
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < MAX_JOBS; i++) job_vld[i] = 1'b0;
    free_sum = mem_units;
  endfunction

  function automatic alloc_rsp_t apply_request(logic [OpW-1:0] op, logic [IdW-1:0] id,
      logic [AddrW-1:0] sz, logic [TimeW-1:0] jt, logic [TimeW-1:0] el);
    alloc_rsp_t r;
    int ord[MAX_JOBS];
    int n, slot, s, freed;
    logic [AddrW-1:0] prev_end, best_gap, best_addr, lim, gap, e, at;
    bit found;
    r = '0;
    freed = 0;
    case (op)
      OP_ALLOC: begin
        slot = -1;
        if (lookup_job(id) >= 0) r.status = ST_DUP;
        else begin
          for (int i = 0; i < MAX_JOBS; i++)
            if (!job_vld[i]) begin slot = i; break; end
          if (slot < 0) r.status = ST_FULL;
        end
        if (r.status == ST_OK) begin
          n = order_jobs(ord);
          prev_end = '0; best_gap = '0; best_addr = '0; found = 0;
          for (int k = 0; k <= n; k++) begin
            lim = (k < n) ? job_base[ord[k]] : mem_units;
            if (lim >= prev_end) begin
              gap = lim - prev_end;
              if (sz != 0 && gap >= sz && (!found || gap < best_gap)) begin
                found = 1; best_gap = gap; best_addr = prev_end;
              end
            end
            if (k < n) begin
              e = job_base[ord[k]] + job_len[ord[k]];
              if (e > prev_end) prev_end = e;
            end
          end
          if (!found) r.status = ST_NO_FIT;
          else begin
            job_vld[slot] = 1; job_id[slot] = id; job_base[slot] = best_addr;
            job_len[slot] = sz; job_life[slot] = TlW'(jt);
            free_sum = free_sum - sz;
            r.start_addr = best_addr;
          end
        end
      end
      OP_FREE: begin
        s = lookup_job(id);
        if (s < 0) r.status = ST_UNKNOWN;
        else begin
          job_vld[s] = 0; free_sum = free_sum + job_len[s]; freed = 1;
        end
      end
      OP_TICK: begin
        for (int i = 0; i < MAX_JOBS; i++) begin
          if (!job_vld[i]) continue;
          if (job_life[i] == 0 || TlW'(el) >= job_life[i]) begin
            job_vld[i] = 0; free_sum = free_sum + job_len[i]; freed++;
          end else job_life[i] = job_life[i] - TlW'(el);
        end
      end
      OP_COMPACT: begin
        n = order_jobs(ord);
        at = '0;
        for (int k = 0; k < n; k++) begin
          job_base[ord[k]] = at;
          at = at + job_len[ord[k]];
        end
      end
      OP_QUERY: begin
        s = lookup_job(id);
        if (s < 0) r.status = ST_UNKNOWN;
        else r.start_addr = job_base[s];
      end
      default: ;
    endcase
    r.free_units = free_sum;
    r.freed_count = (freed > 63) ? 6'd63 : FreedW'(freed);
    return r;
  endfunction

  assign pending_cnt = expected_rsps.size();

  // Predict on request transfers, compare on response transfers
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_rsp_t got, exp_r;
    if (!rst_ni) begin
      mem_units = '0;
      wipe_table();
      expected_rsps.delete();
      fail_cnt = 0;
      rsp_cnt = 0;
    end else begin
      if (cfg_we_i) begin
        mem_units = cfg_wdata_i;
        wipe_table();
      end
      if (req.valid && req.ready)
        expected_rsps.push_back(apply_request(req.op, req.job_id, req.job_size,
                                              req.job_time, req.elapsed));
      if (rsp.valid && rsp.ready) begin
        got = {rsp.status, rsp.start_addr, rsp.free_units, rsp.freed_count};
        rsp_cnt++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: response with none expected, actual %p", $time, got);
          fail_cnt++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (got.status != exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
            fail_cnt++;
          end
          if (got.start_addr != exp_r.start_addr) begin
            $display("%0t: start_addr expected %0d actual %0d", $time,
                     exp_r.start_addr, got.start_addr);
            fail_cnt++;
          end
          if (got.free_units != exp_r.free_units) begin
            $display("%0t: free_units expected %0d actual %0d", $time,
                     exp_r.free_units, got.free_units);
            fail_cnt++;
          end
          if (got.freed_count != exp_r.freed_count) begin
            $display("%0t: freed_count expected %0d actual %0d", $time,
                     exp_r.freed_count, got.freed_count);
            fail_cnt++;
          end
        end
      end
    end
  end

endmodule

FILE: dv/tb_best_fit_partition_allocator.sv
// Testbench top: drives requests, configuration and response back-pressure.
module tb_best_fit_partition_allocator;
  import bfpa_pkg::*;

  localparam int MAX_JOBS = 32;
  localparam int DRAIN_CYC = 2 * MAX_JOBS + 20;

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             cfg_we_i = 0;
  logic [AddrW-1:0] cfg_wdata_i = '0;
  int               fail_cnt, pending_cnt, rsp_cnt;
  int               n_items = 0;
  int               n_cfg = 0;
  bit               idle_on = 1;
  bit               hold_rsp = 0;
  logic [IdW-1:0]   id_pool;

  bfpa_req_if req ();
  bfpa_rsp_if rsp ();

  best_fit_partition_allocator #(.MAX_JOBS(MAX_JOBS)) dut (
    .clk_i, .rst_ni, .req_i(req.sink), .rsp_o(rsp.source), .cfg_we_i, .cfg_wdata_i
  );

  bfpa_checker #(.MAX_JOBS(MAX_JOBS)) u_checker (
    .clk_i, .rst_ni, .req(req.sink), .rsp(rsp.sink), .cfg_we_i, .cfg_wdata_i,
    .fail_cnt, .pending_cnt, .rsp_cnt
  );

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  // Response ready: random stall bursts, or a long hold-off on request
  initial begin
    int stall;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rsp) rsp.ready <= 1'b0;
      else if (stall > 0) begin
        rsp.ready <= 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 6) - 1;
        rsp.ready <= 1'b0;
      end else rsp.ready <= 1'b1;
    end
  end

  // The block is busy after each transfer until its pass ends, so the drop of
  // valid for one cycle between items costs no throughput
  task automatic send_req(logic [OpW-1:0] op, logic [IdW-1:0] id, logic [AddrW-1:0] sz,
                          logic [TimeW-1:0] jt, logic [TimeW-1:0] el);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.job_id <= id;
    req.job_size <= sz;
    req.job_time <= jt;
    req.elapsed <= el;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
    req.valid <= 1'b0;
    @(negedge clk_i);
    n_items++;
  endtask

  // Wait until every response is back, then let the block settle, then write
  task automatic write_mem_size(logic [AddrW-1:0] val);
    int guard;
    guard = 0;
    while (pending_cnt != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYC) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_cfg++;
  endtask

  // Random mix dominated by allocations and frees over a small id pool
  task automatic random_phase(int count, logic [AddrW-1:0] msz);
    int sel;
    logic [AddrW-1:0] sz;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      sz = ($urandom_range(0, 9) == 0) ? AddrW'($urandom)
           : AddrW'($urandom_range(1, (msz > 16) ? msz / 8 : 4));
      if (sel < 40)
        send_req(OP_ALLOC, IdW'($urandom_range(0, 47)) ^ id_pool, sz,
                 ($urandom_range(0, 4) == 0) ? TimeW'($urandom) : TimeW'($urandom_range(1, 40)),
                 TimeW'($urandom));
      else if (sel < 62)
        send_req(OP_FREE, IdW'($urandom_range(0, 47)) ^ id_pool, AddrW'($urandom),
                 TimeW'($urandom), TimeW'($urandom));
      else if (sel < 76)
        send_req(OP_TICK, IdW'($urandom), AddrW'($urandom), TimeW'($urandom),
                 ($urandom_range(0, 9) == 0) ? TimeW'($urandom) : TimeW'($urandom_range(0, 8)));
      else if (sel < 84)
        send_req(OP_COMPACT, IdW'($urandom), AddrW'($urandom), TimeW'($urandom),
                 TimeW'($urandom));
      else if (sel < 97)
        send_req(OP_QUERY, IdW'($urandom_range(0, 47)) ^ id_pool, AddrW'($urandom),
                 TimeW'($urandom), TimeW'($urandom));
      else
        send_req(OpW'($urandom_range(5, 7)), IdW'($urandom), AddrW'($urandom),
                 TimeW'($urandom), TimeW'($urandom));
    end
  endtask

  initial begin
    logic [AddrW-1:0] msz;
    int guard;
    req.valid = 1'b0;
    req.op = '0;
    req.job_id = '0;
    req.job_size = '0;
    req.job_time = '0;
    req.elapsed = '0;
    id_pool = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: zero memory, then a small space covering the special cases
    send_req(OP_ALLOC, 16'd1, 20'd1, 16'd1, 16'd0);
    write_mem_size(20'd100);
    send_req(OP_ALLOC, 16'd1, 20'd30, 16'd5, 16'd0);
    send_req(OP_ALLOC, 16'd1, 20'd5, 16'd5, 16'd0);          // duplicate id
    send_req(OP_ALLOC, 16'd2, 20'd0, 16'd5, 16'd0);          // zero size
    send_req(OP_ALLOC, 16'd2, 20'd20, 16'd0, 16'd0);         // zero lifetime
    send_req(OP_ALLOC, 16'hFFFF, 20'd50, 16'hFFFF, 16'd0);
    send_req(OP_ALLOC, 16'd3, 20'hFFFFF, 16'd3, 16'd0);      // no fit
    send_req(OP_FREE, 16'd2, 20'd0, 16'd0, 16'd0);
    send_req(OP_ALLOC, 16'd4, 20'd10, 16'd9, 16'd0);         // best fit in 20-unit hole
    send_req(OP_QUERY, 16'd4, 20'd0, 16'd0, 16'd0);
    send_req(OP_FREE, 16'd7, 20'd0, 16'd0, 16'd0);           // unknown
    send_req(OP_QUERY, 16'd7, 20'd0, 16'd0, 16'd0);
    send_req(OP_COMPACT, 16'd0, 20'd0, 16'd0, 16'd0);
    send_req(OP_QUERY, 16'hFFFF, 20'd0, 16'd0, 16'd0);
    send_req(OP_TICK, 16'd0, 20'd0, 16'd0, 16'd5);           // exact expiry
    send_req(OP_TICK, 16'd0, 20'd0, 16'd0, 16'hFFFF);
    send_req(3'd7, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
    // Fill the table: 32 one-unit jobs, then table full
    write_mem_size(20'hFFFFF);
    for (int i = 0; i < MAX_JOBS; i++)
      send_req(OP_ALLOC, IdW'(i + 100), 20'd1, 16'd0, 16'd0);
    send_req(OP_ALLOC, 16'd999, 20'd1, 16'd1, 16'd0);
    send_req(OP_ALLOC, 16'd100, 20'd1, 16'd1, 16'd0);
    send_req(OP_TICK, 16'd0, 20'd0, 16'd0, 16'd0);           // all expire at once

    // Long receiver hold-off while requests keep coming
    hold_rsp = 1;
    fork
      begin
        int cyc;
        cyc = 0;
        while (cyc < 300) begin
          @(negedge clk_i);
          cyc++;
        end
        hold_rsp = 0;
      end
      random_phase(12, 20'hFFFFF);
    join

    // Random phases over several memory sizes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: msz = 20'd64;
        1: msz = 20'hFFFFF;
        2: msz = 20'd1;
        default: msz = AddrW'($urandom_range(16, 4000));
      endcase
      id_pool = IdW'($urandom);
      write_mem_size(msz);
      if (ph == 7) idle_on = 0;
      random_phase(190, msz);
    end

    guard = 0;
    while (pending_cnt != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYC) @(negedge clk_i);
    if (pending_cnt != 0) begin
      $display("%0t: %0d responses never arrived", $time, pending_cnt);
      $display("Verification failed");
      $finish;
    end
    $display("Covered %0d requests, %0d responses, %0d mem_size writes up to the maximum,",
             n_items, rsp_cnt, n_cfg);
    $display("plus the empty space left by reset, a full table and a long response hold-off.");
    if (fail_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bfpa_pkg.sv
hw/rtl/bfpa_if.sv
hw/rtl/bfpa_ram.sv
hw/rtl/bfpa_gap.sv
hw/rtl/best_fit_partition_allocator.sv
dv/bfpa_checker.sv
dv/tb_best_fit_partition_allocator.sv
